### hw/rtl/lzsr_pkg.sv
// Shared types and constants for the LZSS ring decompressor.
`timescale 1ns / 1ps
package lzsr_pkg;

  // History ring geometry
  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned RING_AW    = 12;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 29;
  localparam int unsigned LEN_W      = 5;

  // Stream start values
  localparam logic [RING_AW-1:0] RING_START = 12'hFEE;
  localparam logic [CNT_W-1:0]   CAP_RESET  = 29'd65536;
  localparam logic [3:0]         FLAG_EMPTY = 4'd8;

  // Reference length is the low nibble plus this bias
  localparam logic [LEN_W-1:0]   MATCH_BIAS = 5'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_COPY,
    ST_REPORT
  } state_t;

endpackage

### hw/rtl/lzsr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module lzsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/lzss_ring_decompressor_unit.sv
// Top level of the LZSS ring decompressor: decode control, ring copy engine, output word.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in_     | input     | in_valid / in_ready  | in_data_byte, in_last_in_stream
//   out_    | output    | out_valid/out_ready  | out_byte, out_byte_valid, out_run_last,
//           |           |                      | out_stream_done, out_bytes_written
//   cfg_    | input     | cfg_valid/cfg_ready  | cfg_output_capacity
//
// Sequence: each input byte is taken in idle and handled in decode; a reference's second
// byte then runs the copy state, where the ring RAM gives one read per cycle while the
// output slot is free, and each copied byte is one output word. A stream end with no byte
// out passes through the report state for the done word.
// Reset: synchronous, active low. No clearing pass: a ring entry not yet written in the
// current stream is detected from the byte count and reads as zero.
// Stalls: while out_ready is low with a word held, the copy engine freezes in place.
`timescale 1ns / 1ps
module lzss_ring_decompressor_unit
  import lzsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // compressed input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_in_stream,
  // decompressed output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_byte_valid,
  output logic              out_run_last,
  output logic              out_stream_done,
  output logic [CNT_W-1:0]  out_bytes_written,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_output_capacity
);

  // Control and decode state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cap_r;
  logic [RING_AW-1:0] wp_r, wp_nxt;
  logic [BYTE_W-1:0]  flags_r, flags_nxt;
  logic [3:0]         fidx_r, fidx_nxt;
  logic [BYTE_W-1:0]  pend_r, pend_nxt;
  logic               await_r, await_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Captured input word
  logic [BYTE_W-1:0]  byte_r;
  logic               last_r;

  // Copy engine
  logic [RING_AW-1:0] src_r, src_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic               fwd_r, fwd_nxt;
  logic [BYTE_W-1:0]  fwd_data_r, fwd_data_nxt;
  logic               zero_r, zero_nxt;

  // Output word
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_bv_r, out_bv_nxt;
  logic               out_rl_r, out_rl_nxt;
  logic               out_sd_r, out_sd_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  // Ring port
  logic               ring_we;
  logic [BYTE_W-1:0]  ring_wdata;
  logic               ring_re;
  logic [RING_AW-1:0] ring_raddr;
  logic [BYTE_W-1:0]  ring_rdata;

  // Decode helpers
  logic               active;
  logic               slot_free;
  logic [CNT_W-1:0]   cnt_inc;
  logic               need_flag;
  logic               cur_bit;
  logic [RING_AW-1:0] ref_off;
  logic [LEN_W-1:0]   ref_len;
  logic [BYTE_W-1:0]  copy_data;
  logic               copy_end;
  logic               restart;

  // True when addr has been written in this stream, given cnt bytes emitted from RING_START
  function automatic logic ring_written(input logic [RING_AW-1:0] addr,
                                        input logic [CNT_W-1:0]   cnt);
    logic [RING_AW-1:0] span;
    span = addr - RING_START;
    return (cnt[CNT_W-1:RING_AW] != '0) || (span < cnt[RING_AW-1:0]);
  endfunction

  assign active    = cnt_r < cap_r;
  assign slot_free = !out_valid_r || out_ready;
  assign cnt_inc   = cnt_r + 1'b1;
  assign need_flag = fidx_r[3];
  assign cur_bit   = flags_r[fidx_r[2:0]];
  assign ref_off   = {byte_r[7:4], pend_r};
  assign ref_len   = {1'b0, byte_r[3:0]} + MATCH_BIAS;
  assign copy_data = fwd_r ? fwd_data_r : (zero_r ? '0 : ring_rdata);
  assign copy_end  = (rem_r == LEN_W'(1)) || (cnt_inc >= cap_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!active || need_flag || (!cur_bit && !await_r)) begin
          state_nxt = last_r ? ST_REPORT : ST_IDLE;
        end else if (cur_bit) begin
          if (slot_free) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        if (slot_free && copy_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output word
  always_comb begin
    wp_nxt        = wp_r;
    flags_nxt     = flags_r;
    fidx_nxt      = fidx_r;
    pend_nxt      = pend_r;
    await_nxt     = await_r;
    cnt_nxt       = cnt_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    fwd_nxt       = fwd_r;
    fwd_data_nxt  = fwd_data_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_rl_nxt    = out_rl_r;
    out_sd_nxt    = out_sd_r;
    out_cnt_nxt   = out_cnt_r;
    ring_we       = 1'b0;
    ring_wdata    = byte_r;
    ring_re       = 1'b0;
    ring_raddr    = src_r;
    restart       = 1'b0;

    case (state_r)
      ST_DECODE: begin
        if (!active) begin
          // consume and ignore
        end else if (need_flag) begin
          flags_nxt = byte_r;
          fidx_nxt  = '0;
        end else if (cur_bit) begin
          // literal: emit and record in the ring
          if (slot_free) begin
            ring_we       = 1'b1;
            ring_wdata    = byte_r;
            wp_nxt        = wp_r + 1'b1;
            cnt_nxt       = cnt_inc;
            fidx_nxt      = fidx_r + 1'b1;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = byte_r;
            out_bv_nxt    = 1'b1;
            out_rl_nxt    = 1'b1;
            out_sd_nxt    = last_r;
            out_cnt_nxt   = cnt_inc;
            restart       = last_r;
          end
        end else if (!await_r) begin
          pend_nxt  = byte_r;
          await_nxt = 1'b1;
        end else begin
          // reference: issue the first ring read
          ring_re   = 1'b1;
          ring_raddr = ref_off;
          src_nxt   = ref_off + 1'b1;
          rem_nxt   = ref_len;
          fwd_nxt   = 1'b0;
          zero_nxt  = !ring_written(ref_off, cnt_r);
          await_nxt = 1'b0;
          fidx_nxt  = fidx_r + 1'b1;
        end
      end
      ST_COPY: begin
        if (slot_free) begin
          ring_we       = 1'b1;
          ring_wdata    = copy_data;
          wp_nxt        = wp_r + 1'b1;
          cnt_nxt       = cnt_inc;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = copy_data;
          out_bv_nxt    = 1'b1;
          out_rl_nxt    = copy_end;
          out_sd_nxt    = copy_end && last_r;
          out_cnt_nxt   = cnt_inc;
          if (copy_end) begin
            restart = last_r;
          end else begin
            // advance; forward the byte written now if the next read hits it
            ring_re      = 1'b1;
            ring_raddr   = src_r;
            src_nxt      = src_r + 1'b1;
            rem_nxt      = rem_r - 1'b1;
            fwd_nxt      = (src_r == wp_r);
            fwd_data_nxt = copy_data;
            zero_nxt     = !ring_written(src_r, cnt_inc);
          end
        end
      end
      ST_REPORT: begin
        // pure done report
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_bv_nxt    = 1'b0;
          out_rl_nxt    = 1'b1;
          out_sd_nxt    = 1'b1;
          out_cnt_nxt   = cnt_r;
          restart       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Return to stream start state
    if (restart) begin
      wp_nxt    = RING_START;
      flags_nxt = '0;
      fidx_nxt  = FLAG_EMPTY;
      pend_nxt  = '0;
      await_nxt = 1'b0;
      cnt_nxt   = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      wp_r        <= RING_START;
      flags_r     <= '0;
      fidx_r      <= FLAG_EMPTY;
      pend_r      <= '0;
      await_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
      zero_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      flags_r     <= flags_nxt;
      fidx_r      <= fidx_nxt;
      pend_r      <= pend_nxt;
      await_r     <= await_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= fwd_nxt;
      zero_r      <= zero_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_output_capacity;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      last_r <= in_last_in_stream;
    end
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_rl_r   <= out_rl_nxt;
    out_sd_r   <= out_sd_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // History ring
  lzsr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp_r),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign in_ready          = (state_r == ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_byte_valid    = out_bv_r;
  assign out_run_last      = out_rl_r;
  assign out_stream_done   = out_sd_r;
  assign out_bytes_written = out_cnt_r;

  // A running copy always has bytes left to move
  a_copy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> (rem_r != '0))
    else $error("copy engine running with no bytes left");

  // Ring writes only come from a literal or a copy step
  a_ring_we: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> (state_r == ST_DECODE || state_r == ST_COPY))
    else $error("ring written outside decode or copy");

  // A done word closes the run of its input word
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_done) |-> out_run_last)
    else $error("stream done without run last");

  // A forwarded read follows a ring write in the cycle before
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(fwd_r)) |-> $past(ring_we))
    else $error("forwarding without a preceding ring write");

endmodule

### tb/lzss_ring_decompressor_unit_test.sv
// Testbench for the LZSS ring decompressor: directed and random streams checked word by word.
`timescale 1ns / 1ps
module lzss_ring_decompressor_unit_test;
  import lzsr_pkg::*;

  localparam logic [CNT_W-1:0] CAP_MAX = 29'd268435456;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 180;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              run_last;
    logic              stream_done;
    logic [CNT_W-1:0]  count;
  } out_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_last_in_stream = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_byte_valid;
  logic              out_run_last;
  logic              out_stream_done;
  logic [CNT_W-1:0]  out_bytes_written;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_output_capacity = '0;

  // Local copy of the decoder state
  logic [BYTE_W-1:0]  history_mem [RING_DEPTH];
  logic [RING_AW-1:0] hist_wr;
  logic [BYTE_W-1:0]  flag_reg;
  logic [3:0]         flag_pos;
  logic [BYTE_W-1:0]  low_half;
  logic               second_due;
  logic [CNT_W-1:0]   byte_count;
  logic [CNT_W-1:0]   capacity = CAP_RESET;

  out_word_t expected_words[$];
  logic [3:0] copy_high;
  bit tx_throttle = 1'b1;
  bit rx_throttle = 1'b1;
  int ready_wait = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int words_checked = 0;
  int streams_closed = 0;
  int cfg_writes = 0;
  int error_count = 0;

  lzss_ring_decompressor_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_in_stream   (in_last_in_stream),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_run_last        (out_run_last),
    .out_stream_done     (out_stream_done),
    .out_bytes_written   (out_bytes_written),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Return the ring and the token state to stream start
  task automatic restart_history();
    int i;
    for (i = 0; i < RING_DEPTH; i++) history_mem[i] = '0;
    hist_wr    = RING_START;
    flag_reg   = '0;
    flag_pos   = FLAG_EMPTY;
    low_half   = '0;
    second_due = 1'b0;
    byte_count = '0;
  endtask

  // Write one decoded byte into the ring and build its output word
  function automatic out_word_t ring_emit(input logic [BYTE_W-1:0] b);
    out_word_t w;
    history_mem[hist_wr] = b;
    hist_wr    = hist_wr + 1'b1;
    byte_count = byte_count + 1'b1;
    w = '{data: b, byte_valid: 1'b1, run_last: 1'b0, stream_done: 1'b0, count: byte_count};
    return w;
  endfunction

  // Decode one compressed byte and queue the words it should produce
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    out_word_t run_q[$];
    logic [RING_AW-1:0] rd;
    logic [LEN_W-1:0] len;
    int i;
    if (byte_count < capacity) begin
      if (flag_pos >= FLAG_EMPTY) begin
        flag_reg = b;
        flag_pos = '0;
      end else if (flag_reg[flag_pos[2:0]]) begin
        run_q.push_back(ring_emit(b));
        flag_pos = flag_pos + 1'b1;
      end else if (!second_due) begin
        low_half   = b;
        second_due = 1'b1;
      end else begin
        rd  = {b[7:4], low_half};
        len = {1'b0, b[3:0]} + MATCH_BIAS;
        // copy byte by byte so an overlapping copy sees its own output
        for (i = 0; i < int'(len) && byte_count < capacity; i++) begin
          run_q.push_back(ring_emit(history_mem[rd]));
          rd = rd + 1'b1;
        end
        second_due = 1'b0;
        flag_pos   = flag_pos + 1'b1;
      end
    end
    if (last) begin
      if (run_q.size() == 0)
        run_q.push_back('{data: '0, byte_valid: 1'b0, run_last: 1'b0, stream_done: 1'b0,
                          count: byte_count});
      run_q[run_q.size()-1].stream_done = 1'b1;
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].run_last = 1'b1;
    foreach (run_q[k]) expected_words.push_back(run_q[k]);
    if (last) restart_history();
  endtask

  // Offer one compressed word and hold it until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = tx_throttle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_last_in_stream <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, last);
    items_sent++;
  endtask

  // Drop valid and wait until every queued word has come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain_outputs();
    cfg_valid           <= 1'b1;
    cfg_output_capacity <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity = value;
    cfg_writes++;
  endtask

  // Next byte of a well-formed stream, following the current token position
  function automatic logic [BYTE_W-1:0] shaped_byte();
    logic [RING_AW-1:0] off;
    logic [RING_AW-1:0] span;
    int r;
    r = $urandom;
    if (byte_count >= capacity || flag_pos >= FLAG_EMPTY || flag_reg[flag_pos[2:0]])
      return r[7:0];
    if (!second_due) begin
      // mostly point a little behind the write position so the copy sees real data
      span = {6'd0, r[17:12]} + 1'b1;
      off  = ($urandom_range(0, 3) == 0) ? r[11:0] : hist_wr - span;
      copy_high = off[11:8];
      return off[7:0];
    end
    return {copy_high, r[3:0]};
  endfunction

  function automatic logic [CNT_W-1:0] random_capacity();
    int r;
    logic [CNT_W-1:0] v;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: v = CAP_MAX;
      1: v = CNT_W'($urandom_range(1, 30));
      2: v = CAP_RESET;
      default: v = {1'b0, r[27:0]};
    endcase
    if (v == '0) v = CNT_W'(1);
    return v;
  endfunction

  // Hold the receiver off at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_wait > 0) begin
      ready_wait = ready_wait - 1;
    end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      ready_wait = pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count < 30)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Check each word on the falling edge before the rising edge that accepts it
  always @(negedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count < 30)
          $display("%0t: unexpected word, expected none, actual byte %0h count %0h",
                   $time, out_byte, out_bytes_written);
      end else begin
        want = expected_words.pop_front();
        check_field("out_byte", CNT_W'(want.data), CNT_W'(out_byte));
        check_field("out_byte_valid", CNT_W'(want.byte_valid), CNT_W'(out_byte_valid));
        check_field("out_run_last", CNT_W'(want.run_last), CNT_W'(out_run_last));
        check_field("out_stream_done", CNT_W'(want.stream_done), CNT_W'(out_stream_done));
        check_field("out_bytes_written", want.count, out_bytes_written);
        if (want.stream_done) streams_closed++;
        words_checked++;
      end
    end
  end

  // End the run if no handshake happens for too long
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d words still expected",
                 $time, idle_cycles, expected_words.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Literals, overlapping copies, wrap of the offset, unwritten entries, half reference
  task automatic test_literals_and_references();
    send_byte(8'h83, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // Flag byte that ends the stream, literal that ends the stream
  task automatic test_stream_edges();
    send_byte(8'hC3, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  // Copy cut at the capacity, bytes past the capacity, capacity lowered mid-stream
  task automatic test_capacity_limits();
    write_capacity(29'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h34, 1'b1);
    write_capacity(CAP_MAX);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h5A, 1'b1);
    write_capacity(CAP_RESET);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    // sender waits here until the decoder is empty
    write_capacity(29'd2);
    send_byte(8'h66, 1'b1);
  endtask

  // Mostly well-formed streams with random content, some pure noise
  task automatic test_random_streams();
    int goal;
    int stream_len;
    int k;
    bit noisy;
    int r;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      tx_throttle = ($urandom_range(0, 3) != 0);
      rx_throttle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) write_capacity(random_capacity());
      noisy = ($urandom_range(0, 7) == 0);
      stream_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 45);
      for (k = 0; k < stream_len; k++) begin
        if (k == stream_len / 2 && k > 0 && $urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1) == 0) write_capacity(random_capacity());
          else drain_outputs();
        end
        r = $urandom;
        send_byte(noisy ? r[7:0] : shaped_byte(), k == stream_len - 1);
      end
    end
  endtask

  initial begin
    restart_history();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literals_and_references();
    test_stream_edges();
    test_capacity_limits();
    test_random_streams();
    drain_outputs();
    $display("Sent %0d compressed bytes over %0d streams with %0d capacity writes.",
             items_sent, streams_closed, cfg_writes);
    $display("Checked %0d output words, %0d mismatches.", words_checked, error_count);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
